// ===== rtl/core/sat_pkg.sv =====
// Shared types and constants for the shell argument tokenizer.
`default_nettype none

package sat_pkg;

    localparam int MaxLine = 4096;
    localparam int PosLimitInt = ((MaxLine - 1) < 4095) ? (MaxLine - 1) : 4095;
    localparam logic [11:0] PosLimit = PosLimitInt[11:0];
    localparam logic [11:0] LenLimit = 12'd4095;
    localparam logic [12:0] CountLimit = 13'd4096;
    localparam logic [12:0] SizeLimit = 13'd8191;

    localparam logic [7:0] ChSquote = 8'h27;
    localparam logic [7:0] ChDquote = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;

    localparam int FifoDepth = 4;

    typedef enum logic [2:0] {
        LEX_NORMAL,
        LEX_SQUOTE,
        LEX_DQUOTE,
        LEX_DQ_ESC,
        LEX_ESC
    } t_lex_mode;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_END,
        KIND_DONE
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_UNTERM,
        ST_TRAIL_BSL
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_char;
        logic [12:0] arg_index;
        t_status     status;
        logic [11:0] error_position;
        logic [12:0] arg_count;
        logic [12:0] total_size;
        logic        last;
    } t_result;

    // Results produced by one item: count 0..2, res0 first.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/core/sat_lex.sv =====
// Lexer state and per-byte result generation for the argument tokenizer.
`default_nettype none

module sat_lex
    import sat_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_ch,
    output t_push           o_push
);

    t_lex_mode   r_mode, n_mode;
    logic        r_in_arg, n_in_arg;
    logic [11:0] r_pos, n_pos;
    logic [11:0] r_open, n_open;
    logic [12:0] r_count, n_count;
    logic [12:0] r_size, n_size;
    logic [11:0] r_len, n_len;

    logic [13:0] sum;
    logic [12:0] close_size;
    logic [12:0] close_count;
    logic [11:0] len_inc1;
    logic [11:0] len_inc2;
    logic        is_space;
    t_result     char_res;
    t_result     end_res;
    t_result     done_res;

    always_comb begin
        sum         = {1'b0, r_size} + {2'b00, r_len} + 14'd1;
        close_size  = (sum > {1'b0, SizeLimit}) ? SizeLimit : sum[12:0];
        close_count = (r_count < CountLimit) ? r_count + 13'd1 : r_count;
        len_inc1    = (r_len < LenLimit) ? r_len + 12'd1 : r_len;
        len_inc2    = (r_len < LenLimit - 12'd1) ? r_len + 12'd2 : LenLimit;
        is_space    = ((i_ch >= 8'd9) && (i_ch <= 8'd13)) || (i_ch == 8'd32);

        char_res           = '0;
        char_res.kind      = KIND_CHAR;
        char_res.out_char  = i_ch;
        char_res.arg_index = r_count;
        char_res.status    = ST_OK;

        end_res           = '0;
        end_res.kind      = KIND_END;
        end_res.arg_index = r_count;
        end_res.status    = ST_OK;

        done_res            = '0;
        done_res.kind       = KIND_DONE;
        done_res.status     = ST_OK;
        done_res.arg_count  = r_count;
        done_res.total_size = r_size;
        done_res.last       = 1'b1;

        n_mode   = r_mode;
        n_in_arg = r_in_arg;
        n_pos    = (r_pos < PosLimit) ? r_pos + 12'd1 : r_pos;
        n_open   = r_open;
        n_count  = r_count;
        n_size   = r_size;
        n_len    = r_len;
        o_push   = '0;

        if (i_ch == 8'd0) begin
            unique case (r_mode)
                LEX_SQUOTE, LEX_DQUOTE, LEX_DQ_ESC: begin
                    done_res.status         = ST_UNTERM;
                    done_res.error_position = r_open;
                    o_push.cnt              = 2'd1;
                    o_push.res0             = done_res;
                end
                LEX_ESC: begin
                    done_res.status         = ST_TRAIL_BSL;
                    done_res.error_position = r_open;
                    o_push.cnt              = 2'd1;
                    o_push.res0             = done_res;
                end
                default: begin
                    if (r_in_arg) begin
                        // Close the open argument, then report the line.
                        done_res.arg_count  = close_count;
                        done_res.total_size = close_size;
                        o_push.cnt          = 2'd2;
                        o_push.res0         = end_res;
                        o_push.res1         = done_res;
                    end else begin
                        o_push.cnt  = 2'd1;
                        o_push.res0 = done_res;
                    end
                end
            endcase
            // Start a fresh line.
            n_mode   = LEX_NORMAL;
            n_in_arg = 1'b0;
            n_pos    = '0;
            n_open   = '0;
            n_count  = '0;
            n_size   = '0;
            n_len    = '0;
        end else begin
            unique case (r_mode)
                LEX_SQUOTE: begin
                    if (i_ch == ChSquote) begin
                        n_mode = LEX_NORMAL;
                    end else begin
                        n_in_arg    = 1'b1;
                        n_len       = len_inc1;
                        o_push.cnt  = 2'd1;
                        o_push.res0 = char_res;
                    end
                end
                LEX_DQUOTE: begin
                    if (i_ch == ChDquote) begin
                        n_mode = LEX_NORMAL;
                    end else if (i_ch == ChBslash) begin
                        n_mode = LEX_DQ_ESC;
                    end else begin
                        n_in_arg    = 1'b1;
                        n_len       = len_inc1;
                        o_push.cnt  = 2'd1;
                        o_push.res0 = char_res;
                    end
                end
                LEX_DQ_ESC: begin
                    n_mode   = LEX_DQUOTE;
                    n_in_arg = 1'b1;
                    if ((i_ch != ChBslash) && (i_ch != ChDquote)) begin
                        // Keep the backslash as a literal before the byte.
                        n_len                = len_inc2;
                        o_push.cnt           = 2'd2;
                        o_push.res0          = char_res;
                        o_push.res0.out_char = ChBslash;
                        o_push.res1          = char_res;
                        o_push.res1.last     = 1'b1;
                    end else begin
                        n_len       = len_inc1;
                        o_push.cnt  = 2'd1;
                        o_push.res0 = char_res;
                    end
                end
                LEX_ESC: begin
                    n_mode      = LEX_NORMAL;
                    n_in_arg    = 1'b1;
                    n_len       = len_inc1;
                    o_push.cnt  = 2'd1;
                    o_push.res0 = char_res;
                end
                default: begin
                    n_mode = LEX_NORMAL;
                    if (is_space) begin
                        if (r_in_arg) begin
                            n_count     = close_count;
                            n_size      = close_size;
                            n_in_arg    = 1'b0;
                            n_len       = '0;
                            o_push.cnt  = 2'd1;
                            o_push.res0 = end_res;
                        end
                    end else if (i_ch == ChSquote) begin
                        n_open = r_pos;
                        n_mode = LEX_SQUOTE;
                    end else if (i_ch == ChDquote) begin
                        n_open = r_pos;
                        n_mode = LEX_DQUOTE;
                    end else if (i_ch == ChBslash) begin
                        n_open = r_pos;
                        n_mode = LEX_ESC;
                    end else begin
                        n_in_arg    = 1'b1;
                        n_len       = len_inc1;
                        o_push.cnt  = 2'd1;
                        o_push.res0 = char_res;
                    end
                end
            endcase
            // The single result of an item is its last one.
            if (o_push.cnt == 2'd1) begin
                o_push.res0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= LEX_NORMAL;
            r_in_arg <= 1'b0;
            r_pos    <= '0;
            r_open   <= '0;
            r_count  <= '0;
            r_size   <= '0;
            r_len    <= '0;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_in_arg <= n_in_arg;
            r_pos    <= n_pos;
            r_open   <= n_open;
            r_count  <= n_count;
            r_size   <= n_size;
            r_len    <= n_len;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sat_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one unless stalled.
`default_nettype none

module sat_fifo
    import sat_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_en,
    input  wire t_push i_push,
    output logic       o_room,
    output logic       o_valid,
    input  wire logic  i_stall,
    output t_result    o_res
);

    localparam int AddrW = $clog2(FifoDepth);
    localparam int CntW  = $clog2(FifoDepth + 1);
    localparam logic [CntW-1:0] RoomMax = CntW'(FifoDepth - 2);

    t_result           r_mem [FifoDepth];
    logic [AddrW-1:0]  r_wr, n_wr;
    logic [AddrW-1:0]  r_rd, n_rd;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic [AddrW-1:0]  wr_next;
    logic [CntW-1:0]   push_n;
    logic              pop;

    always_comb begin
        o_room  = (r_cnt <= RoomMax);
        o_valid = (r_cnt != '0);
        o_res   = r_mem[r_rd];
        pop     = o_valid && !i_stall;
        push_n  = i_push_en ? CntW'(i_push.cnt) : '0;
        wr_next = r_wr + AddrW'(1);
        n_wr    = r_wr + AddrW'(push_n);
        n_rd    = pop ? r_rd + AddrW'(1) : r_rd;
        n_cnt   = r_cnt + push_n - (pop ? CntW'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_en && (i_push.cnt != 2'd0)) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push_en && (i_push.cnt == 2'd2)) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/shell_argument_tokenizer_top.sv =====
// Top level of the shell-style command line argument tokenizer.
//
// Input channel (i_valid / o_stall): one command-line byte per item on
// i_ch; a byte of 0 ends the line. An item is taken at a clock edge with
// i_valid high and o_stall low.
// Output channel (o_valid / i_stall): one result item per handshake:
// argument characters, argument ends and a line-done item carrying the
// argument count, total size, status and error position. o_last marks
// the final result caused by an input byte; a byte may cause none.
// A byte lands in the input register at its accept edge; its results enter
// the four-entry result queue once the queue has room for two results,
// and are offered from the head of the queue.
// Throughput: one byte per cycle. A byte that yields two results (line end
// with an open argument, or a kept backslash inside double quotes) adds a
// queue entry that drains at one result per cycle while i_stall is low;
// the input stalls only while the queue lacks room for two results.
// Reset (synchronous, active low): empties the queue, drops any held byte
// and returns the lexer to the start of a line outside any quote.
// When the receiver stalls, the head result holds steady and the queue
// fills; with three or more results queued and a byte held, o_stall rises.
`default_nettype none

module shell_argument_tokenizer_top
    import sat_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_ch,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_out_char,
    output logic [12:0]      o_arg_index,
    output logic [1:0]       o_status,
    output logic [11:0]      o_error_position,
    output logic [12:0]      o_arg_count,
    output logic [12:0]      o_total_size,
    output logic             o_last
);

    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_ch;
    logic        fifo_room;
    logic        fire;
    logic        accept;
    t_push       push;
    t_result     head;

    // Process the held byte whenever the queue can absorb two results.
    always_comb begin
        fire       = r_in_valid && fifo_room;
        o_stall    = r_in_valid && !fifo_room;
        accept     = i_valid && !o_stall;
        n_in_valid = accept ? 1'b1 : (fire ? 1'b0 : r_in_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Byte register: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_ch <= i_ch;
        end
    end

    sat_lex u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_ch    (r_in_ch),
        .o_push  (push)
    );

    sat_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (fire),
        .i_push    (push),
        .o_room    (fifo_room),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (head)
    );

    assign o_kind           = head.kind;
    assign o_out_char       = head.out_char;
    assign o_arg_index      = head.arg_index;
    assign o_status         = head.status;
    assign o_error_position = head.error_position;
    assign o_arg_count      = head.arg_count;
    assign o_total_size     = head.total_size;
    assign o_last           = head.last;

endmodule

`default_nettype wire

// ===== bench/sat_line_model_pkg.sv =====
// Predicted tokenizer results for each accepted byte, and the result checks.
package sat_line_model_pkg;
    import sat_pkg::*;

    function automatic bit is_blank(logic [7:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
    endfunction

    class token_checker;
        t_lex_mode   mode;
        bit          in_arg;
        logic [11:0] pos;
        logic [11:0] open_pos;
        logic [11:0] cur_len;
        logic [12:0] arg_total;
        logic [12:0] size_sum;
        t_result     batch[$];
        t_result     expected_tokens[$];
        int          errors;

        function new();
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            mode      = LEX_NORMAL;
            in_arg    = 1'b0;
            pos       = '0;
            open_pos  = '0;
            cur_len   = '0;
            arg_total = '0;
            size_sum  = '0;
        endfunction

        function void add_char(logic [7:0] c);
            t_result r;
            r = '0;
            in_arg = 1'b1;
            if (cur_len < LenLimit) cur_len = cur_len + 1'b1;
            r.kind      = KIND_CHAR;
            r.out_char  = c;
            r.arg_index = arg_total;
            batch.insert(batch.size(), r);
        endfunction

        function void close_word();
            t_result r;
            int      sum;
            if (!in_arg) return;
            r = '0;
            r.kind      = KIND_END;
            r.arg_index = arg_total;
            batch.insert(batch.size(), r);
            if (arg_total < CountLimit) arg_total = arg_total + 1'b1;
            sum = int'(size_sum) + int'(cur_len) + 1;
            size_sum = (sum > int'(SizeLimit)) ? SizeLimit : 13'(sum);
            in_arg  = 1'b0;
            cur_len = '0;
        endfunction

        function void note_byte(logic [7:0] ch);
            t_result r;
            batch.delete();
            if (ch == 8'h00) begin
                r = '0;
                r.kind = KIND_DONE;
                if (mode == LEX_SQUOTE || mode == LEX_DQUOTE || mode == LEX_DQ_ESC) begin
                    r.status         = ST_UNTERM;
                    r.error_position = open_pos;
                end else if (mode == LEX_ESC) begin
                    r.status         = ST_TRAIL_BSL;
                    r.error_position = open_pos;
                end else begin
                    close_word();
                end
                r.arg_count  = arg_total;
                r.total_size = size_sum;
                batch.insert(batch.size(), r);
                clear_line();
            end else begin
                case (mode)
                    LEX_SQUOTE: begin
                        if (ch == ChSquote) mode = LEX_NORMAL;
                        else add_char(ch);
                    end
                    LEX_DQUOTE: begin
                        if (ch == ChDquote) mode = LEX_NORMAL;
                        else if (ch == ChBslash) mode = LEX_DQ_ESC;
                        else add_char(ch);
                    end
                    LEX_DQ_ESC: begin
                        // keep the backslash unless it escapes a backslash or a quote
                        if (ch != ChBslash && ch != ChDquote) add_char(ChBslash);
                        add_char(ch);
                        mode = LEX_DQUOTE;
                    end
                    LEX_ESC: begin
                        add_char(ch);
                        mode = LEX_NORMAL;
                    end
                    default: begin
                        mode = LEX_NORMAL;
                        if (is_blank(ch)) begin
                            close_word();
                        end else if (ch == ChSquote) begin
                            open_pos = pos;
                            mode     = LEX_SQUOTE;
                        end else if (ch == ChDquote) begin
                            open_pos = pos;
                            mode     = LEX_DQUOTE;
                        end else if (ch == ChBslash) begin
                            open_pos = pos;
                            mode     = LEX_ESC;
                        end else begin
                            add_char(ch);
                        end
                    end
                endcase
                if (pos < PosLimit) pos = pos + 1'b1;
            end
            if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) expected_tokens.insert(expected_tokens.size(), batch[i]);
        endfunction

        task report(string msg);
            $display("[tb] mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_tokens.size() == 0) begin
                report($sformatf("result with nothing pending: kind %0d char %02h",
                                 got.kind, got.out_char));
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind != want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.out_char != want.out_char)
                report($sformatf("out_char %02h, want %02h", got.out_char, want.out_char));
            if (got.arg_index != want.arg_index)
                report($sformatf("arg_index %0d, want %0d", got.arg_index, want.arg_index));
            if (got.status != want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.error_position != want.error_position)
                report($sformatf("error_position %0d, want %0d",
                                 got.error_position, want.error_position));
            if (got.arg_count != want.arg_count)
                report($sformatf("arg_count %0d, want %0d", got.arg_count, want.arg_count));
            if (got.total_size != want.total_size)
                report($sformatf("total_size %0d, want %0d", got.total_size, want.total_size));
            if (got.last != want.last)
                report($sformatf("last %0b, want %0b", got.last, want.last));
        endtask
    endclass

endpackage

// ===== bench/shell_argument_tokenizer_top_tb.sv =====
// Self-checking bench for the shell argument tokenizer top level.
module shell_argument_tokenizer_top_tb;
    import sat_pkg::*;
    import sat_line_model_pkg::*;

    // Longest legal quiet stretch is a long gap followed by a long stall;
    // allow far more before calling the run hung.
    localparam int IdleLimit   = 1000;
    localparam int TailCycles  = 8;
    localparam int RandomItems = 800;

    localparam logic [7:0] LineEnd = 8'h00;
    localparam logic [7:0] Space   = 8'h20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_ch;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_char;
    logic [12:0] o_arg_index;
    logic [1:0]  o_status;
    logic [11:0] o_error_position;
    logic [12:0] o_arg_count;
    logic [12:0] o_total_size;
    logic        o_last;

    token_checker sb = new();
    t_result      seen;
    int           idle_cycles = 0;
    int           items_sent  = 0;
    bit           calm        = 1'b0;

    shell_argument_tokenizer_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_ch             (i_ch),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_out_char       (o_out_char),
        .o_arg_index      (o_arg_index),
        .o_status         (o_status),
        .o_error_position (o_error_position),
        .o_arg_count      (o_arg_count),
        .o_total_size     (o_total_size),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly back-to-back, often a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random nonzero byte that is neither a nor b.
    function automatic logic [7:0] pick_other(logic [7:0] a, logic [7:0] b);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == a || c == b);
        return c;
    endfunction

    // Offer one byte at a falling edge, hold it until taken, then note it.
    // Enter and leave at a falling edge so valid changes only there.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= b;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        sb.note_byte(b);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Build one command line from words, blanks, quoted strings and escapes.
    // A few lines are raw noise or end inside a quote or after a backslash.
    task automatic send_random_line();
        int         n;
        logic [7:0] c;
        calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    repeat ($urandom_range(1, 6)) begin
                        do c = pick_other(ChSquote, ChDquote);
                        while (c == ChBslash || is_blank(c));
                        send_byte(c);
                    end
                end
                2: begin
                    repeat ($urandom_range(1, 3)) begin
                        c = 8'($urandom_range(8, 14));
                        send_byte((c < 8'd9 || c > 8'd13) ? Space : c);
                    end
                end
                3: begin
                    send_byte(ChSquote);
                    repeat ($urandom_range(0, 5)) send_byte(pick_other(ChSquote, ChSquote));
                    send_byte(ChSquote);
                end
                4: begin
                    send_byte(ChDquote);
                    repeat ($urandom_range(0, 5)) begin
                        if ($urandom_range(0, 2) == 0) begin
                            send_byte(ChBslash);
                            case ($urandom_range(0, 2))
                                0: send_byte(ChBslash);
                                1: send_byte(ChDquote);
                                default: send_byte(pick_other(ChDquote, ChBslash));
                            endcase
                        end else begin
                            send_byte(pick_other(ChDquote, ChBslash));
                        end
                    end
                    send_byte(ChDquote);
                end
                default: begin
                    send_byte(ChBslash);
                    send_byte(8'($urandom_range(1, 255)));
                end
            endcase
        end
        // break the line now and then: leave a quote, an escape or a backslash open
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: send_byte(ChSquote);
                1: send_byte(ChDquote);
                2: begin
                    send_byte(ChDquote);
                    send_byte(ChBslash);
                end
                default: send_byte(ChBslash);
            endcase
        end
        send_byte(LineEnd);
    endtask

    // Release results at random: short runs with pauses, some long clear runs.
    initial begin
        int run;
        int hold;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
            i_stall <= 1'b0;
            repeat (run) @(negedge i_clk);
            hold = pick_gap();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
        end
    end

    // Check each taken result against the oldest prediction; watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                seen.kind           = t_kind'(o_kind);
                seen.out_char       = o_out_char;
                seen.arg_index      = o_arg_index;
                seen.status         = t_status'(o_status);
                seen.error_position = o_error_position;
                seen.arg_count      = o_arg_count;
                seen.total_size     = o_total_size;
                seen.last           = o_last;
                sb.check_result(seen);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("shell_argument_tokenizer_top_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] seq[$];
        int         start;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ch    = 8'h00;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed lines: lowest and highest bytes, every blank, empty quotes
        // inside a word and alone, all double-quote escapes including a kept
        // backslash, a quoted part joining a word, high bytes, each error at
        // the terminator, and an empty line.
        seq = '{8'h01, ChSquote, ChSquote, 8'h09, ChDquote, ChDquote, 8'h0A,
                ChDquote, ChBslash, ChDquote, ChBslash, ChBslash, ChBslash, 8'h71,
                ChDquote, 8'h0B, 8'h0C, 8'h0D, Space, 8'hFF, ChSquote, 8'h80,
                ChSquote, ChBslash, Space, LineEnd,
                ChSquote, LineEnd,
                ChDquote, LineEnd,
                ChDquote, ChBslash, LineEnd,
                ChBslash, LineEnd,
                LineEnd};
        foreach (seq[i]) send_byte(seq[i]);

        start = items_sent;
        while (items_sent - start < RandomItems) send_random_line();
        i_valid <= 1'b0;

        // Drain, then give a late or stray result time to show up.
        while (sb.expected_tokens.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
        if (sb.expected_tokens.size() != 0)
            sb.report($sformatf("%0d results never came", sb.expected_tokens.size()));
        if (sb.errors == 0) begin
            $display("shell_argument_tokenizer_top_tb: clean");
        end else begin
            $display("shell_argument_tokenizer_top_tb: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sat_pkg.sv
rtl/core/sat_lex.sv
rtl/core/sat_fifo.sv
rtl/core/shell_argument_tokenizer_top.sv
bench/sat_line_model_pkg.sv
bench/shell_argument_tokenizer_top_tb.sv
